// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: %m");

// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen: %m");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

// ===== hw/rtl/lbs_pkg.sv =====
`timescale 1ns / 1ps
// types, sizes and codes of the loop jump backpatch stack
package lbs_pkg;

   localparam int STACK_DEPTH       = 16;
   localparam int PATCHES_PER_LEVEL = 16;
   localparam int ADDR_BITS         = 24;

   localparam int IN_W    = ADDR_BITS + 1;
   localparam int OFF_W   = ADDR_BITS + 2;
   localparam int LVL_W   = $clog2(STACK_DEPTH + 1);
   localparam int FILL_W  = $clog2(PATCHES_PER_LEVEL + 1);
   localparam int LIDX_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int SLOT_W  = (PATCHES_PER_LEVEL > 1) ? $clog2(PATCHES_PER_LEVEL) : 1;
   localparam int MEM_AW  = 1 + LIDX_W + SLOT_W;
   localparam int MEM_DEPTH = 2 ** MEM_AW;
   localparam int PATCH_LEN = 4;

   typedef logic signed [IN_W-1:0]  addr_type;
   typedef logic [ADDR_BITS-1:0]    pos_type;
   typedef logic signed [OFF_W-1:0] off_type;
   typedef logic [LVL_W-1:0]        lvl_type;
   typedef logic [FILL_W-1:0]       fill_type;
   typedef logic [LIDX_W-1:0]       lidx_type;
   typedef logic [MEM_AW-1:0]       maddr_type;

   localparam addr_type UNKNOWN_TARGET = '1;

   typedef enum logic [1:0] {
      MODE_PUSH     = 2'd0,
      MODE_ADD_BRK  = 2'd1,
      MODE_ADD_CONT = 2'd2,
      MODE_POP      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_OVERFLOW     = 3'd1,
      ST_BRK_OUTSIDE  = 3'd2,
      ST_CONT_OUTSIDE = 3'd3,
      ST_DROPPED      = 3'd4,
      ST_POP_EMPTY    = 3'd5
   } status_type;

   // updates requested of the level file
   typedef struct packed {
      logic     push;
      logic     add_brk;
      logic     add_cont;
      logic     pop;
      addr_type target;
   } lvl_cmd_type;

   // innermost level as seen by the sequencer
   typedef struct packed {
      lvl_type  level;
      logic     empty;
      logic     full;
      lidx_type top_idx;
      lidx_type push_idx;
      addr_type ctgt;
      fill_type bfill;
      fill_type cfill;
   } lvl_view_type;

endpackage

// ===== hw/rtl/lbs_if.sv =====
`timescale 1ns / 1ps
// handshake channels for loop events and patch results
interface lbs_req_if import lbs_pkg::*; ();
   logic     valid;
   logic     ready;
   mode_type mode;
   addr_type addr;

   modport source (output valid, output mode, output addr, input ready);
   modport sink   (input valid, input mode, input addr, output ready);
endinterface

interface lbs_rsp_if import lbs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       write_valid;
   pos_type    patch_position;
   off_type    relative_offset;
   logic       is_break;
   logic       last;
   status_type status;

   modport source (output valid, output write_valid, output patch_position,
                   output relative_offset, output is_break, output last,
                   output status, input ready);
   modport sink   (input valid, input write_valid, input patch_position,
                   input relative_offset, input is_break, input last,
                   input status, output ready);
endinterface

// ===== hw/rtl/lbs_pos_mem.sv =====
`timescale 1ns / 1ps
// patch position memory, break and continue lists of every level
module lbs_pos_mem import lbs_pkg::*; (
   input  logic      clock,
   input  logic      wr_en,
   input  maddr_type wr_addr,
   input  pos_type   wr_data,
   input  logic      rd_en,
   input  maddr_type rd_addr,
   output pos_type   rd_data
);

   pos_type mem [MEM_DEPTH];
   pos_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lbs_disp_unit.sv =====
`timescale 1ns / 1ps
// shared displacement adder: target - (position + 4), registered
module lbs_disp_unit import lbs_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  addr_type target,
   input  pos_type  pos,
   output off_type  off
);

   off_type off_ff;
   off_type off_in;
   off_type tgt_ext;
   off_type pos_end;

   always_comb begin
      tgt_ext = OFF_W'(target);
      pos_end = off_type'({2'b00, pos}) + OFF_W'(PATCH_LEN);
      off_in  = tgt_ext - pos_end;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         off_ff <= off_in;
      end
   end

   assign off = off_ff;

endmodule

// ===== hw/rtl/lbs_level_file.sv =====
`timescale 1ns / 1ps
// nesting level, continue targets and fill counts of the open loops
module lbs_level_file import lbs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  lvl_cmd_type  cmd,
   output lvl_view_type view
);

   lvl_type  level_ff;
   lvl_type  level_in;
   addr_type ctgt_ff  [STACK_DEPTH];
   fill_type bfill_ff [STACK_DEPTH];
   fill_type cfill_ff [STACK_DEPTH];
   lvl_type  top_lvl;
   lidx_type top_idx;
   lidx_type push_idx;

   always_comb begin
      top_lvl  = level_ff - LVL_W'(1);
      top_idx  = top_lvl[LIDX_W-1:0];
      push_idx = level_ff[LIDX_W-1:0];
      level_in = level_ff;
      if (cmd.push) begin
         level_in = level_ff + LVL_W'(1);
      end else if (cmd.pop) begin
         level_in = top_lvl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // per-level storage, undefined until a push opens the level
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         ctgt_ff[push_idx]  <= cmd.target;
         bfill_ff[push_idx] <= '0;
         cfill_ff[push_idx] <= '0;
      end
      if (cmd.add_brk) begin
         bfill_ff[top_idx] <= bfill_ff[top_idx] + FILL_W'(1);
      end
      if (cmd.add_cont) begin
         cfill_ff[top_idx] <= cfill_ff[top_idx] + FILL_W'(1);
      end
   end

   always_comb begin
      view.level    = level_ff;
      view.empty    = (level_ff == '0);
      view.full     = (level_ff == LVL_W'(STACK_DEPTH));
      view.top_idx  = top_idx;
      view.push_idx = push_idx;
      view.ctgt     = ctgt_ff[top_idx];
      view.bfill    = bfill_ff[top_idx];
      view.cfill    = cfill_ff[top_idx];
   end

endmodule

// ===== hw/rtl/loop_jump_backpatch_stack_top.sv =====
`timescale 1ns / 1ps
// loop jump backpatch stack: sequencer, output register and assertions
//
//  channel  dir  beat
//  req_ch   in   mode, addr
//  rsp_ch   out  write_valid, patch_position, relative_offset, is_break, last, status
//
// push, add and pops with nothing to patch give one beat. a pop with patch
// writes walks each write through S_READ for the position memory read,
// S_CALC for the shared displacement adder and S_EMIT to load the output
// register, which waits while the sink holds rsp_ch.ready low.
// req_ch.ready is low for the whole walk. synchronous reset clears the
// nesting level and the handshake state; stored lists need no clearing.
`include "assert_macros.svh"

module loop_jump_backpatch_stack_top import lbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   lbs_req_if.sink        req_ch,
   lbs_rsp_if.source      rsp_ch
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CALC,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic       kind_brk_ff, kind_brk_in;
   fill_type   slot_ff, slot_in;
   fill_type   nb_ff, nb_in;
   fill_type   nc_ff, nc_in;
   addr_type   brk_tgt_ff, brk_tgt_in;
   addr_type   cont_tgt_ff, cont_tgt_in;
   lidx_type   lidx_ff, lidx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_wv_ff, rsp_wv_in;
   pos_type    rsp_pos_ff, rsp_pos_in;
   off_type    rsp_off_ff, rsp_off_in;
   logic       rsp_brk_ff, rsp_brk_in;
   logic       rsp_last_ff, rsp_last_in;
   status_type rsp_status_ff, rsp_status_in;

   lvl_cmd_type  lvl_cmd;
   lvl_view_type view;

   logic       out_free;
   logic       req_accept;
   logic       mem_wr_en;
   maddr_type  mem_wr_addr;
   logic       mem_rd_en;
   maddr_type  mem_rd_addr;
   pos_type    mem_rd_data;
   logic       disp_en;
   addr_type   disp_tgt;
   off_type    disp_off;
   fill_type   slot_next;
   fill_type   pop_nc;
   logic       more_in_list;
   logic       final_write;
   fill_type   add_fill;

   lbs_level_file u_level (
      .clock (clock),
      .reset (reset),
      .cmd   (lvl_cmd),
      .view  (view)
   );

   lbs_pos_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_ch.addr[ADDR_BITS-1:0]),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lbs_disp_unit u_disp (
      .clock  (clock),
      .en     (disp_en),
      .target (disp_tgt),
      .pos    (mem_rd_data),
      .off    (disp_off)
   );

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ch.ready;
      req_ch.ready  = (state_ff == S_IDLE) && out_free;
      req_accept    = req_ch.valid && req_ch.ready;

      slot_next     = slot_ff + FILL_W'(1);
      more_in_list  = slot_next < (kind_brk_ff ? nb_ff : nc_ff);
      final_write   = !more_in_list && !(kind_brk_ff && (nc_ff != '0));
      pop_nc        = (view.ctgt != UNKNOWN_TARGET) ? view.cfill : '0;
      add_fill      = (req_ch.mode == MODE_ADD_BRK) ? view.bfill : view.cfill;

      mem_wr_addr   = {req_ch.mode == MODE_ADD_BRK, view.top_idx, add_fill[SLOT_W-1:0]};
      mem_rd_addr   = {kind_brk_ff, lidx_ff, slot_ff[SLOT_W-1:0]};
      mem_rd_en     = (state_ff == S_READ);
      disp_en       = (state_ff == S_CALC);
      disp_tgt      = kind_brk_ff ? brk_tgt_ff : cont_tgt_ff;

      lvl_cmd        = '0;
      lvl_cmd.target = req_ch.addr;
      mem_wr_en      = 1'b0;

      state_in      = state_ff;
      kind_brk_in   = kind_brk_ff;
      slot_in       = slot_ff;
      nb_in         = nb_ff;
      nc_in         = nc_ff;
      brk_tgt_in    = brk_tgt_ff;
      cont_tgt_in   = cont_tgt_ff;
      lidx_in       = lidx_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_wv_in     = rsp_wv_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_brk_in    = rsp_brk_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               // single status beat unless a pop has writes to walk
               rsp_valid_in  = 1'b1;
               rsp_wv_in     = 1'b0;
               rsp_pos_in    = '0;
               rsp_off_in    = '0;
               rsp_brk_in    = 1'b0;
               rsp_last_in   = 1'b1;
               rsp_status_in = ST_OK;
               case (req_ch.mode)
                  MODE_PUSH: begin
                     if (view.full) begin
                        rsp_status_in = ST_OVERFLOW;
                     end else begin
                        lvl_cmd.push = 1'b1;
                     end
                  end
                  MODE_ADD_BRK, MODE_ADD_CONT: begin
                     if (view.empty) begin
                        rsp_status_in = (req_ch.mode == MODE_ADD_BRK) ?
                                        ST_BRK_OUTSIDE : ST_CONT_OUTSIDE;
                     end else if (add_fill == FILL_W'(PATCHES_PER_LEVEL)) begin
                        rsp_status_in = ST_DROPPED;
                     end else begin
                        mem_wr_en        = 1'b1;
                        lvl_cmd.add_brk  = (req_ch.mode == MODE_ADD_BRK);
                        lvl_cmd.add_cont = (req_ch.mode == MODE_ADD_CONT);
                     end
                  end
                  MODE_POP: begin
                     if (view.empty) begin
                        rsp_status_in = ST_POP_EMPTY;
                     end else begin
                        lvl_cmd.pop = 1'b1;
                        nb_in       = view.bfill;
                        nc_in       = pop_nc;
                        brk_tgt_in  = req_ch.addr;
                        cont_tgt_in = view.ctgt;
                        lidx_in     = view.top_idx;
                        slot_in     = '0;
                        kind_brk_in = (view.bfill != '0);
                        if ((view.bfill != '0) || (pop_nc != '0)) begin
                           rsp_valid_in = 1'b0;
                           state_in     = S_READ;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_CALC;
         end
         S_CALC: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_wv_in     = 1'b1;
               rsp_pos_in    = mem_rd_data;
               rsp_off_in    = disp_off;
               rsp_brk_in    = kind_brk_ff;
               rsp_last_in   = final_write;
               rsp_status_in = ST_OK;
               if (final_write) begin
                  state_in = S_IDLE;
               end else if (more_in_list) begin
                  slot_in  = slot_next;
                  state_in = S_READ;
               end else begin
                  // break list done, continue list next
                  kind_brk_in = 1'b0;
                  slot_in     = '0;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_brk_ff   <= kind_brk_in;
      slot_ff       <= slot_in;
      nb_ff         <= nb_in;
      nc_ff         <= nc_in;
      brk_tgt_ff    <= brk_tgt_in;
      cont_tgt_ff   <= cont_tgt_in;
      lidx_ff       <= lidx_in;
      rsp_wv_ff     <= rsp_wv_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_brk_ff    <= rsp_brk_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.write_valid     = rsp_wv_ff;
   assign rsp_ch.patch_position  = rsp_pos_ff;
   assign rsp_ch.relative_offset = rsp_off_ff;
   assign rsp_ch.is_break        = rsp_brk_ff;
   assign rsp_ch.last            = rsp_last_ff;
   assign rsp_ch.status          = rsp_status_ff;

   `ASSERT_NEVER(a_level_bound, clock, reset, view.level > LVL_W'(STACK_DEPTH))

   `ASSERT_CLK(a_status_beat_last, clock, reset, (rsp_ch.valid && !rsp_ch.write_valid) |-> rsp_ch.last)

   `ASSERT_CLK(a_pop_drops_level, clock, reset, (req_accept && req_ch.mode == MODE_POP && !view.empty) |=> (view.level == $past(view.level) - LVL_W'(1)))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for the loop jump backpatch stack: directed and random loop events
module testbench;
   import lbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 6 * PATCHES_PER_LEVEL + 20;
   localparam int RANDOM_EVENTS  = 327;
   localparam pos_type POS_MAX   = '1;

   typedef struct packed {
      logic       write_valid;
      pos_type    patch_position;
      off_type    relative_offset;
      logic       is_break;
      logic       last;
      status_type status;
   } patch_beat_t;

   logic clock = 1'b0;
   logic reset;

   lbs_req_if req_ch ();
   lbs_rsp_if rsp_ch ();

   loop_jump_backpatch_stack_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // mirror of the loop stack
   int         level_count;
   addr_type   cont_target [STACK_DEPTH];
   pos_type    brk_slots   [STACK_DEPTH][PATCHES_PER_LEVEL];
   pos_type    cont_slots  [STACK_DEPTH][PATCHES_PER_LEVEL];
   int         brk_fill    [STACK_DEPTH];
   int         cont_fill   [STACK_DEPTH];

   patch_beat_t patch_queue[$];
   int          fail_count;
   int          burst_left;
   int          quiet_cycles;

   function automatic off_type jump_offset(addr_type target, pos_type pos);
      longint d;
      d = longint'(target) - longint'(pos) - 4;
      return off_type'(d);
   endfunction

   function automatic void queue_status(status_type st);
      patch_beat_t b;
      b = '0;
      b.last   = 1'b1;
      b.status = st;
      patch_queue.push_back(b);
   endfunction

   function automatic void queue_write(pos_type pos, addr_type target, logic brk,
                                       logic last);
      patch_beat_t b;
      b.write_valid     = 1'b1;
      b.patch_position  = pos;
      b.relative_offset = jump_offset(target, pos);
      b.is_break        = brk;
      b.last            = last;
      b.status          = ST_OK;
      patch_queue.push_back(b);
   endfunction

   function automatic void apply_loop_event(mode_type m, addr_type a);
      int lv;
      int nb;
      int nc;
      int k;
      case (m)
         MODE_PUSH: begin
            if (level_count >= STACK_DEPTH) begin
               queue_status(ST_OVERFLOW);
            end else begin
               cont_target[level_count] = a;
               brk_fill[level_count]    = 0;
               cont_fill[level_count]   = 0;
               level_count++;
               queue_status(ST_OK);
            end
         end
         MODE_ADD_BRK, MODE_ADD_CONT: begin
            if (level_count == 0) begin
               queue_status(m == MODE_ADD_BRK ? ST_BRK_OUTSIDE : ST_CONT_OUTSIDE);
            end else begin
               lv = level_count - 1;
               if (m == MODE_ADD_BRK) begin
                  if (brk_fill[lv] >= PATCHES_PER_LEVEL) begin
                     queue_status(ST_DROPPED);
                  end else begin
                     brk_slots[lv][brk_fill[lv]] = a[ADDR_BITS-1:0];
                     brk_fill[lv]++;
                     queue_status(ST_OK);
                  end
               end else begin
                  if (cont_fill[lv] >= PATCHES_PER_LEVEL) begin
                     queue_status(ST_DROPPED);
                  end else begin
                     cont_slots[lv][cont_fill[lv]] = a[ADDR_BITS-1:0];
                     cont_fill[lv]++;
                     queue_status(ST_OK);
                  end
               end
            end
         end
         default: begin
            if (level_count == 0) begin
               queue_status(ST_POP_EMPTY);
            end else begin
               level_count--;
               lv = level_count;
               nb = brk_fill[lv];
               // continue patches of an unknown target are thrown away
               nc = (cont_target[lv] != UNKNOWN_TARGET) ? cont_fill[lv] : 0;
               if (nb + nc == 0) begin
                  queue_status(ST_OK);
               end else begin
                  for (k = 0; k < nb; k++)
                     queue_write(brk_slots[lv][k], a, 1'b1, (k == nb + nc - 1));
                  for (k = 0; k < nc; k++)
                     queue_write(cont_slots[lv][k], cont_target[lv], 1'b0,
                                 (nb + k == nb + nc - 1));
               end
            end
         end
      endcase
   endfunction

   // bursts of beats with random gaps between them
   task automatic send_event(input mode_type m, input addr_type a);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.mode  <= m;
      req_ch.addr  <= a;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_loop_event(m, a);
   endtask

   task automatic hold_until_drained();
      req_ch.valid <= 1'b0;
      while (patch_queue.size() != 0) @(posedge clock);
   endtask

   function automatic addr_type pick_addr();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return addr_type'({1'b0, POS_MAX});
         2:       return UNKNOWN_TARGET;
         3, 4, 5: return addr_type'($urandom_range(0, 255));
         default: return addr_type'({1'b0, pos_type'($urandom())});
      endcase
   endfunction

   function automatic addr_type pos_addr(pos_type p);
      return addr_type'({1'b0, p});
   endfunction

   task automatic test_outside_loop();
      send_event(MODE_POP, '0);
      send_event(MODE_ADD_BRK, pos_addr(POS_MAX));
      send_event(MODE_ADD_CONT, UNKNOWN_TARGET);
   endtask

   // widest displacements both ways, plus a nested level closed first
   task automatic test_extreme_positions();
      send_event(MODE_PUSH, '0);
      send_event(MODE_ADD_BRK, '0);
      send_event(MODE_PUSH, pos_addr(POS_MAX));
      send_event(MODE_ADD_CONT, '0);
      send_event(MODE_ADD_BRK, pos_addr(24'h123456));
      send_event(MODE_POP, '0);
      send_event(MODE_ADD_BRK, pos_addr(POS_MAX));
      send_event(MODE_ADD_BRK, UNKNOWN_TARGET);
      send_event(MODE_ADD_CONT, pos_addr(POS_MAX));
      send_event(MODE_POP, pos_addr(POS_MAX));
   endtask

   task automatic test_unknown_continue();
      send_event(MODE_PUSH, UNKNOWN_TARGET);
      send_event(MODE_ADD_BRK, pos_addr(24'd8));
      send_event(MODE_ADD_CONT, pos_addr(24'd12));
      send_event(MODE_POP, UNKNOWN_TARGET);
      send_event(MODE_PUSH, UNKNOWN_TARGET);
      send_event(MODE_ADD_CONT, pos_addr(24'd5));
      send_event(MODE_POP, pos_addr(24'd100));
      send_event(MODE_PUSH, pos_addr(24'h10));
      send_event(MODE_POP, pos_addr(24'h20));
   endtask

   task automatic test_nesting_overflow();
      int i;
      for (i = 0; i < STACK_DEPTH; i++) send_event(MODE_PUSH, pick_addr());
      send_event(MODE_PUSH, pick_addr());
      send_event(MODE_ADD_BRK, pos_addr(24'h10));
      send_event(MODE_ADD_CONT, pos_addr(24'h20));
      for (i = 0; i < STACK_DEPTH; i++) send_event(MODE_POP, pick_addr());
   endtask

   // both lists filled past the end, then one pop with every write
   task automatic test_full_patch_lists();
      int i;
      send_event(MODE_PUSH, pos_addr(24'h1000));
      for (i = 0; i <= PATCHES_PER_LEVEL; i++)
         send_event(MODE_ADD_BRK, addr_type'($urandom_range(0, 24'hFFFF)));
      for (i = 0; i <= PATCHES_PER_LEVEL; i++)
         send_event(MODE_ADD_CONT, addr_type'($urandom_range(0, 24'hFFFF)));
      send_event(MODE_POP, pos_addr(24'h2000));
   endtask

   task automatic test_random_loops(input int count);
      int i;
      int shape;
      int r;
      int push_w;
      int add_w;
      mode_type m;
      addr_type a;
      shape = 0;
      for (i = 0; i < count; i++) begin
         if (i % 40 == 0) shape = $urandom_range(0, 3);
         if (i == count / 2) hold_until_drained();
         case (shape)
            1:       begin push_w = 45; add_w = 30; end
            2:       begin push_w = 15; add_w = 70; end
            default: begin push_w = 20; add_w = 50; end
         endcase
         r = $urandom_range(0, 99);
         if (shape == 3) begin
            // noise: any event regardless of nesting
            m = mode_type'($urandom_range(0, 3));
         end else if (level_count == 0) begin
            if (r < 90)      m = MODE_PUSH;
            else if (r < 93) m = MODE_ADD_BRK;
            else if (r < 96) m = MODE_ADD_CONT;
            else             m = MODE_POP;
         end else begin
            if (r < push_w)                m = MODE_PUSH;
            else if (r < push_w + add_w/2) m = MODE_ADD_BRK;
            else if (r < push_w + add_w)   m = MODE_ADD_CONT;
            else                           m = MODE_POP;
         end
         a = pick_addr();
         if (m == MODE_PUSH && $urandom_range(0, 4) == 0) a = UNKNOWN_TARGET;
         send_event(m, a);
      end
   endtask

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.mode  <= MODE_PUSH;
      req_ch.addr  <= '0;
      level_count  = 0;
      fail_count   = 0;
      burst_left   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_outside_loop();
      test_extreme_positions();
      test_unknown_continue();
      test_nesting_overflow();
      test_full_patch_lists();
      test_random_loops(RANDOM_EVENTS);

      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // result side stalls on a pattern of its own
   initial begin
      int pattern;
      int phase_left;
      int hold;
      logic level;
      pattern    = 0;
      phase_left = 0;
      hold       = 0;
      level      = 1'b1;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            pattern    = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 200);
         end
         phase_left--;
         case (pattern)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               if (hold == 0) begin
                  level = ~level;
                  hold  = $urandom_range(1, 12);
               end
               hold--;
               rsp_ch.ready <= level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      patch_beat_t got;
      patch_beat_t want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = '{rsp_ch.write_valid, rsp_ch.patch_position, rsp_ch.relative_offset,
                 rsp_ch.is_break, rsp_ch.last, rsp_ch.status};
         if (patch_queue.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: unexpected beat wv=%0b pos=%h off=%0d brk=%0b last=%0b st=%0d",
                        $time, got.write_valid, got.patch_position, got.relative_offset,
                        got.is_break, got.last, got.status);
         end else begin
            want = patch_queue.pop_front();
            if (got !== want) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: mismatch, expected wv=%0b pos=%h off=%0d brk=%0b last=%0b",
                            " st=%0d, got wv=%0b pos=%h off=%0d brk=%0b last=%0b st=%0d"},
                           $time, want.write_valid, want.patch_position,
                           want.relative_offset, want.is_break, want.last, want.status,
                           got.write_valid, got.patch_position, got.relative_offset,
                           got.is_break, got.last, got.status);
            end
         end
      end
   end

   // ends a run in which nothing moves on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule
